// ----- design/barometric_pressure_compensation_defines.svh -----
// ----------------------------------------------------------------------------
// Barometric pressure compensation: assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH

`ifndef SYNTH
`define BPC_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bpc: same-cycle check failed");
`define BPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bpc: next-cycle check failed");
`else
`define BPC_ASSERT_IMPLY(lbl, ante, cons)
`define BPC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/bpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, register indexes, status codes and constants.
// ----------------------------------------------------------------------------
package bpc_pkg;

	// pipelined divider: numerator and divisor widths, one quotient bit a stage
	localparam int DIV_NW = 48;
	localparam int DIV_DW = 32;

	localparam int CFG_IW = 3;

	localparam logic [CFG_IW-1:0] REG_AC1_AC2 = 3'd0;
	localparam logic [CFG_IW-1:0] REG_AC3_AC4 = 3'd1;
	localparam logic [CFG_IW-1:0] REG_AC5_AC6 = 3'd2;
	localparam logic [CFG_IW-1:0] REG_B1_B2   = 3'd3;
	localparam logic [CFG_IW-1:0] REG_MC_MD   = 3'd4;
	localparam logic [CFG_IW-1:0] REG_OSS     = 3'd5;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_TDIV0  = 2'd1;
	localparam logic [1:0] ST_RANGE  = 2'd2;
	localparam logic [1:0] ST_B4ZERO = 2'd3;

	localparam int B6_OFFSET   = 4000;
	localparam int PRESS_SCALE = 50000;
	localparam int X3_BIAS     = 32768;
	localparam int C_X1        = 3038;
	localparam int C_X2        = -7357;
	localparam int C_P_OFFSET  = 3791;
	localparam int MC_SHIFT    = 11;

	typedef struct packed {
		logic signed [15:0] ac1;
		logic signed [15:0] ac2;
		logic signed [15:0] ac3;
		logic [15:0]        ac4;
		logic [15:0]        ac5;
		logic [15:0]        ac6;
		logic signed [15:0] b1;
		logic signed [15:0] b2;
		logic signed [15:0] mc;
		logic signed [15:0] md;
		logic [1:0]         oss;
	} coeff_t;

	typedef struct packed {
		logic signed [18:0] x1;
		logic [18:0]        up;
		logic               qneg;
		logic               tzero;
	} side1_t;

	typedef struct packed {
		logic signed [24:0] temp;
		logic [1:0]         st;
		logic               narrow;
	} side2_t;

endpackage

// ----- design/barometric_pressure_compensation.sv -----
`timescale 1ns / 1ps
// A request runs through stages 1-2, divider 1, stages 3-11, divider 2, stages 12-15.
// Throughput: one request per cycle if unstalled; two 48-stage dividers set the depth.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (arst_n low, asynchronous) clears all valid bits and the coefficient registers.
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Pipelined integer temperature and pressure compensation from raw ADC words.
// ----------------------------------------------------------------------------
`include "barometric_pressure_compensation_defines.svh"

module barometric_pressure_compensation (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bpc_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [31:0]                 cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [15:0]                 raw_temperature,
	input  logic [23:0]                 raw_pressure_bytes,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [31:0]          temperature_tenths,
	output logic signed [31:0]          pressure_pa,
	output logic [1:0]                  status
);

	localparam int NW = bpc_pkg::DIV_NW;
	localparam int DW = bpc_pkg::DIV_DW;

	bpc_pkg::coeff_t cfg;
	logic adv;

	bpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coeff     (cfg)
	);

	assign adv      = ~out_valid | out_ready;
	assign in_ready = adv;

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic v_s12, v_s13, v_s14, v_s15;
	logic d1_vld, d2_vld;

	// ---------------- stage 1: ADC shift, (UT - AC6) * AC5
	logic [3:0]         shamt;
	logic [23:0]        up_full;
	logic signed [16:0] tdiff;
	logic signed [33:0] prod1_w;
	logic signed [33:0] prod1_s1;
	logic [18:0]        up_s1;

	assign shamt   = 4'd8 - {2'b00, cfg.oss};
	assign up_full = raw_pressure_bytes >> shamt;
	assign tdiff   = $signed({1'b0, raw_temperature}) - $signed({1'b0, cfg.ac6});
	assign prod1_w = tdiff * $signed({1'b0, cfg.ac5});

	// ---------------- stage 2: X1, divisor, magnitudes for the divider
	logic signed [18:0] x1_w;
	logic signed [19:0] tdiv_w;
	logic signed [16:0] mc_x;
	logic [16:0]        mc_mag;
	logic [19:0]        tdiv_mag;
	logic [NW-1:0]      num_s2;
	logic [DW-1:0]      den_s2;
	bpc_pkg::side1_t    side1_s2;

	assign x1_w     = $signed(prod1_s1[33:15]);
	assign tdiv_w   = 20'(x1_w) + 20'(cfg.md);
	assign mc_x     = 17'(cfg.mc);
	assign mc_mag   = mc_x[16] ? 17'(-mc_x) : 17'(mc_x);
	assign tdiv_mag = tdiv_w[19] ? 20'(-tdiv_w) : 20'(tdiv_w);

	// divider 1: |MC * 2048| / |X1 + MD|
	logic [NW-1:0] d1_quo;
	logic [DW-1:0] d1_rmd;
	logic [DW-1:0] d1_dsr;

	bpc_div u_div_t (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.start_vld (v_s2),
		.num       (num_s2),
		.den       (den_s2),
		.done_vld  (d1_vld),
		.quo       (d1_quo),
		.rmd       (d1_rmd),
		.dsr       (d1_dsr)
	);

	bpc_pkg::side1_t side1_q [NW];

	// ---------------- stage 3: signed quotient, B5
	bpc_pkg::side1_t    sd1;
	logic signed [27:0] quot_w;
	logic signed [27:0] b5_w;
	logic signed [27:0] b5_s3;
	logic [18:0]        up_s3;
	logic               tzero_s3;

	assign sd1    = side1_q[NW-1];
	assign quot_w = sd1.qneg ? -$signed({1'b0, d1_quo[26:0]}) : $signed({1'b0, d1_quo[26:0]});
	assign b5_w   = 28'(sd1.x1) + quot_w;

	// ---------------- stage 4: temperature, B6
	logic signed [28:0] tsum_w;
	logic signed [24:0] temp_s4;
	logic signed [27:0] b6_s4;
	logic [18:0]        up_s4;
	logic               tzero_s4;

	assign tsum_w = 29'(b5_s3) + 29'sd8;

	// ---------------- stage 5: B6^2, AC2 * B6, AC3 * B6
	logic signed [55:0] sq_s5;
	logic signed [43:0] pa2_s5;
	logic signed [43:0] pa3_s5;
	logic signed [24:0] temp_s5;
	logic [18:0]        up_s5;
	logic               tzero_s5;

	// ---------------- stage 6: partial products of B2 and B1 with B6^2 >> 12
	logic [20:0]        sq_lo;
	logic [20:0]        sq_hi;
	logic signed [37:0] b2lo_s6, b2hi_s6, b1lo_s6, b1hi_s6;
	logic signed [31:0] tx2_s6;
	logic signed [31:0] px1_s6;
	logic signed [24:0] temp_s6;
	logic [18:0]        up_s6;
	logic               tzero_s6;

	assign sq_lo = sq_s5[32:12];
	assign sq_hi = sq_s5[53:33];

	// ---------------- stage 7: recombine the partial products
	logic signed [47:0] m2_w;
	logic signed [47:0] m1_w;
	logic signed [31:0] tx1_s7, tx2_s7, px1_s7, px2_s7;
	logic signed [24:0] temp_s7;
	logic [18:0]        up_s7;
	logic               tzero_s7;

	assign m2_w = (48'(b2hi_s6) <<< 21) + 48'(b2lo_s6);
	assign m1_w = (48'(b1hi_s6) <<< 21) + 48'(b1lo_s6);

	// ---------------- stage 8: the two X3 sums
	logic signed [31:0] ppx_w;
	logic signed [31:0] x3_s8;
	logic signed [29:0] x3p_s8;
	logic signed [24:0] temp_s8;
	logic [18:0]        up_s8;
	logic               tzero_s8;

	assign ppx_w = px1_s7 + px2_s7 + 32'sd2;

	// ---------------- stage 9: B3, B4
	logic signed [33:0] b3a_w;
	logic signed [37:0] b3t_w;
	logic signed [38:0] b3r_w;
	logic signed [30:0] x3k_w;
	logic [46:0]        b4p_w;
	logic signed [31:0] b3_s9;
	logic [31:0]        b4_s9;
	logic               lowx3_s9;
	logic signed [24:0] temp_s9;
	logic [18:0]        up_s9;
	logic               tzero_s9;

	assign b3a_w = (34'(cfg.ac1) <<< 2) + 34'(x3_s8);
	assign b3t_w = (38'(b3a_w) <<< cfg.oss) + 38'sd2;
	// division by four toward zero
	assign b3r_w = 39'(b3t_w) + (b3t_w[37] ? 39'sd3 : 39'sd0);
	assign x3k_w = 31'(x3p_s8) + 31'(bpc_pkg::X3_BIAS);
	assign b4p_w = 47'(cfg.ac4) * 47'(x3k_w[30:0]);

	// ---------------- stage 10: status, UP - B3
	logic signed [31:0] up_ext;
	logic [1:0]         st_w;
	logic [32:0]        diff_s10;
	logic [31:0]        b4_s10;
	logic [1:0]         st_s10;
	logic signed [24:0] temp_s10;

	assign up_ext = $signed({13'b0, up_s9});

	always_comb begin
		if (tzero_s9) begin
			st_w = bpc_pkg::ST_TDIV0;
		end else if (up_ext < b3_s9 || lowx3_s9) begin
			st_w = bpc_pkg::ST_RANGE;
		end else if (b4_s9 == '0) begin
			st_w = bpc_pkg::ST_B4ZERO;
		end else begin
			st_w = bpc_pkg::ST_OK;
		end
	end

	// ---------------- stage 11: B7
	logic [15:0]        scale_w;
	logic [48:0]        b7_w;
	logic [NW-1:0]      b7_s11;
	logic [DW-1:0]      b4_s11;
	logic [1:0]         st_s11;
	logic signed [24:0] temp_s11;

	assign scale_w = 16'(bpc_pkg::PRESS_SCALE >> cfg.oss);
	assign b7_w    = 49'(diff_s10) * 49'(scale_w);

	// divider 2: B7 / B4
	logic [NW-1:0] d2_quo;
	logic [DW-1:0] d2_rmd;
	logic [DW-1:0] d2_dsr;

	bpc_div u_div_p (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.start_vld (v_s11),
		.num       (b7_s11),
		.den       (b4_s11),
		.done_vld  (d2_vld),
		.quo       (d2_quo),
		.rmd       (d2_rmd),
		.dsr       (d2_dsr)
	);

	bpc_pkg::side2_t side2_q [NW];

	// ---------------- stage 12: pressure before correction
	// (2 * B7) / B4 = 2Q, plus one if B7 < 2^31 and the doubled remainder reaches B4
	bpc_pkg::side2_t    sd2;
	logic               inc_w;
	logic signed [31:0] p_s12;
	logic [1:0]         st_s12;
	logic signed [24:0] temp_s12;

	assign sd2   = side2_q[NW-1];
	assign inc_w = sd2.narrow && ({d2_rmd, 1'b0} >= {1'b0, d2_dsr});

	// ---------------- stage 13: (p >> 8)^2, -7357 * p
	logic signed [23:0] p8_w;
	logic signed [47:0] psq_w;
	logic [31:0]        x1a_s13;
	logic signed [45:0] m7_s13;
	logic signed [31:0] p_s13;
	logic [1:0]         st_s13;
	logic signed [24:0] temp_s13;

	assign p8_w  = p_s12[31:8];
	assign psq_w = p8_w * p8_w;

	// ---------------- stage 14: X1 * 3038
	logic signed [44:0] x1bp_w;
	logic signed [28:0] x1b_s14;
	logic signed [29:0] x2_s14;
	logic signed [31:0] p_s14;
	logic [1:0]         st_s14;
	logic signed [24:0] temp_s14;

	assign x1bp_w = 45'($signed(x1a_s13)) * 45'(bpc_pkg::C_X1);

	// ---------------- stage 15: final sum into the output register
	logic signed [31:0] cs1_w;
	logic signed [31:0] cs2_w;
	logic signed [31:0] pres_w;

	assign cs1_w  = 32'(x1b_s14) + 32'(x2_s14);
	assign cs2_w  = cs1_w + 32'(bpc_pkg::C_P_OFFSET);
	assign pres_w = p_s14 + 32'($signed(cs2_w[31:4]));

	// ---------------- payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			prod1_s1 <= prod1_w;
			up_s1    <= up_full[18:0];

			num_s2         <= {20'b0, mc_mag, 11'b0};
			den_s2         <= {12'b0, tdiv_mag};
			side1_s2.x1    <= x1_w;
			side1_s2.up    <= up_s1;
			side1_s2.qneg  <= cfg.mc[15] ^ tdiv_w[19];
			side1_s2.tzero <= (tdiv_w == '0);

			side1_q[0] <= side1_s2;
			for (int i = 1; i < NW; i++) begin
				side1_q[i] <= side1_q[i-1];
			end

			b5_s3    <= b5_w;
			up_s3    <= sd1.up;
			tzero_s3 <= sd1.tzero;

			temp_s4  <= tsum_w[28:4];
			b6_s4    <= b5_s3 - 28'(bpc_pkg::B6_OFFSET);
			up_s4    <= up_s3;
			tzero_s4 <= tzero_s3;

			sq_s5    <= b6_s4 * b6_s4;
			pa2_s5   <= cfg.ac2 * b6_s4;
			pa3_s5   <= cfg.ac3 * b6_s4;
			temp_s5  <= temp_s4;
			up_s5    <= up_s4;
			tzero_s5 <= tzero_s4;

			b2lo_s6  <= cfg.b2 * $signed({1'b0, sq_lo});
			b2hi_s6  <= cfg.b2 * $signed({1'b0, sq_hi});
			b1lo_s6  <= cfg.b1 * $signed({1'b0, sq_lo});
			b1hi_s6  <= cfg.b1 * $signed({1'b0, sq_hi});
			tx2_s6   <= pa2_s5[42:11];
			px1_s6   <= 32'($signed(pa3_s5[43:13]));
			temp_s6  <= temp_s5;
			up_s6    <= up_s5;
			tzero_s6 <= tzero_s5;

			tx1_s7   <= m2_w[42:11];
			px2_s7   <= m1_w[47:16];
			tx2_s7   <= tx2_s6;
			px1_s7   <= px1_s6;
			temp_s7  <= temp_s6;
			up_s7    <= up_s6;
			tzero_s7 <= tzero_s6;

			x3_s8    <= tx1_s7 + tx2_s7;
			x3p_s8   <= ppx_w[31:2];
			temp_s8  <= temp_s7;
			up_s8    <= up_s7;
			tzero_s8 <= tzero_s7;

			b3_s9    <= b3r_w[33:2];
			b4_s9    <= b4p_w[46:15];
			lowx3_s9 <= (x3p_s8 < -30'sd32768);
			temp_s9  <= temp_s8;
			up_s9    <= up_s8;
			tzero_s9 <= tzero_s8;

			diff_s10 <= 33'(up_ext) - 33'(b3_s9);
			b4_s10   <= b4_s9;
			st_s10   <= st_w;
			temp_s10 <= temp_s9;

			b7_s11   <= b7_w[NW-1:0];
			b4_s11   <= b4_s10;
			st_s11   <= st_s10;
			temp_s11 <= temp_s10;

			side2_q[0].temp   <= temp_s11;
			side2_q[0].st     <= st_s11;
			side2_q[0].narrow <= (b7_s11[NW-1:31] == '0);
			for (int i = 1; i < NW; i++) begin
				side2_q[i] <= side2_q[i-1];
			end

			p_s12    <= {d2_quo[30:0], inc_w};
			st_s12   <= sd2.st;
			temp_s12 <= sd2.temp;

			x1a_s13  <= psq_w[31:0];
			m7_s13   <= 46'(p_s12) * 46'(bpc_pkg::C_X2);
			p_s13    <= p_s12;
			st_s13   <= st_s12;
			temp_s13 <= temp_s12;

			x1b_s14  <= x1bp_w[44:16];
			x2_s14   <= m7_s13[45:16];
			p_s14    <= p_s13;
			st_s14   <= st_s13;
			temp_s14 <= temp_s13;

			status             <= st_s14;
			temperature_tenths <= (st_s14 == bpc_pkg::ST_TDIV0) ? 32'sd0 : 32'(temp_s14);
			pressure_pa        <= (st_s14 == bpc_pkg::ST_OK) ? pres_w : 32'sd0;
		end
	end

	// ---------------- valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
		end else if (adv) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= d1_vld;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= d2_vld;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
		end
	end

	assign out_valid = v_s15;

	`BPC_ASSERT_IMPLY(a_tdiv_zero_clears, out_valid && status == bpc_pkg::ST_TDIV0, temperature_tenths == 32'sd0 && pressure_pa == 32'sd0)
	`BPC_ASSERT_IMPLY(a_bad_status_no_pressure, out_valid && status != bpc_pkg::ST_OK, pressure_pa == 32'sd0)
	`BPC_ASSERT_NEXT(a_request_enters, in_valid && in_ready, v_s1)

endmodule

// ----- design/bpc_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_cfg
// Coefficient register file, unpacked into signed and unsigned fields.
// ----------------------------------------------------------------------------
module bpc_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bpc_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [31:0]                  cfg_data,
	output bpc_pkg::coeff_t              coeff
);

	logic [31:0] ac1_ac2_q;
	logic [31:0] ac3_ac4_q;
	logic [31:0] ac5_ac6_q;
	logic [31:0] b1_b2_q;
	logic [31:0] mc_md_q;
	logic [1:0]  oss_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac1_ac2_q <= '0;
			ac3_ac4_q <= '0;
			ac5_ac6_q <= '0;
			b1_b2_q   <= '0;
			mc_md_q   <= '0;
			oss_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bpc_pkg::REG_AC1_AC2: ac1_ac2_q <= cfg_data;
				bpc_pkg::REG_AC3_AC4: ac3_ac4_q <= cfg_data;
				bpc_pkg::REG_AC5_AC6: ac5_ac6_q <= cfg_data;
				bpc_pkg::REG_B1_B2:   b1_b2_q   <= cfg_data;
				bpc_pkg::REG_MC_MD:   mc_md_q   <= cfg_data;
				bpc_pkg::REG_OSS:     oss_q     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		coeff.ac1 = ac1_ac2_q[31:16];
		coeff.ac2 = ac1_ac2_q[15:0];
		coeff.ac3 = ac3_ac4_q[31:16];
		coeff.ac4 = ac3_ac4_q[15:0];
		coeff.ac5 = ac5_ac6_q[31:16];
		coeff.ac6 = ac5_ac6_q[15:0];
		coeff.b1  = b1_b2_q[31:16];
		coeff.b2  = b1_b2_q[15:0];
		coeff.mc  = mc_md_q[31:16];
		coeff.md  = mc_md_q[15:0];
		coeff.oss = oss_q;
	end

endmodule

// ----- design/bpc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bpc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        start_vld,
	input  logic [bpc_pkg::DIV_NW-1:0]  num,
	input  logic [bpc_pkg::DIV_DW-1:0]  den,
	output logic                        done_vld,
	output logic [bpc_pkg::DIV_NW-1:0]  quo,
	output logic [bpc_pkg::DIV_DW-1:0]  rmd,
	output logic [bpc_pkg::DIV_DW-1:0]  dsr
);

	localparam int NW = bpc_pkg::DIV_NW;
	localparam int DW = bpc_pkg::DIV_DW;

	// numerator bits shift out of the top while quotient bits shift in below
	logic [NW-1:0] nq_s  [NW];
	logic [DW-1:0] r_s   [NW];
	logic [DW-1:0] d_s   [NW];
	logic [NW-1:0] v_s;

	logic [NW-1:0] nq_in [NW];
	logic [DW-1:0] r_in  [NW];
	logic [DW-1:0] d_in  [NW];
	logic [NW-1:0] nq_nx [NW];
	logic [DW-1:0] r_nx  [NW];
	logic [DW+1:0] trial [NW];

	always_comb begin
		nq_in[0] = num;
		r_in[0]  = '0;
		d_in[0]  = den;
		for (int i = 1; i < NW; i++) begin
			nq_in[i] = nq_s[i-1];
			r_in[i]  = r_s[i-1];
			d_in[i]  = d_s[i-1];
		end
		for (int i = 0; i < NW; i++) begin
			trial[i] = {1'b0, r_in[i], nq_in[i][NW-1]} - {2'b00, d_in[i]};
			nq_nx[i] = {nq_in[i][NW-2:0], ~trial[i][DW+1]};
			r_nx[i]  = trial[i][DW+1] ? {r_in[i][DW-2:0], nq_in[i][NW-1]} : trial[i][DW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NW; i++) begin
				nq_s[i] <= nq_nx[i];
				r_s[i]  <= r_nx[i];
				d_s[i]  <= d_in[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[NW-2:0], start_vld};
		end
	end

	assign done_vld = v_s[NW-1];
	assign quo      = nq_s[NW-1];
	assign rmd      = r_s[NW-1];
	assign dsr      = d_s[NW-1];

endmodule
